### rtl/core/lct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU cache table.
// Used by lct_cell, lru_cache_table and lct_checker; depends on nothing.

package lct_pkg;

  localparam int ENTRIES    = 64;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 7;
  localparam int CMD_W      = 2;

  // Stream word layout, lowest bit first.
  localparam int IN_BITS   = CMD_W + KEY_BITS + VALUE_BITS;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 1 + VALUE_BITS + 1 + KEY_BITS + CNT_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  // Row-wide control broadcast to every cell.
  typedef struct packed {
    logic clear;       // drop every entry
    logic cmp_en;      // latch the key compare
    logic lookup_hit;  // move the matching entry to the front
    logic ins_evict;   // insert, least recent entry falls off the end
    logic ins_grow;    // insert, row grows by one
  } ctrl_t;

endpackage

### rtl/core/lct_cell.sv
`timescale 1ns / 1ps
// One recency slot of the LRU row: holds an entry, compares its key and
// takes over its front neighbor's entry when the row shifts. Uses lct_pkg.

module lct_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lct_pkg::ctrl_t                  ctrl_i,
  input  logic [lct_pkg::KEY_BITS-1:0]    op_key_i,
  input  lct_pkg::entry_t                 prev_i,
  input  logic                            next_valid_i,
  input  logic                            above_match_i,
  output lct_pkg::entry_t                 entry_o,
  output logic                            match_o,
  output logic                            last_o
);

  logic                              valid_q, valid_d;
  logic                              match_q;
  logic [lct_pkg::KEY_BITS-1:0]      key_q;
  logic [lct_pkg::VALUE_BITS-1:0]    value_q;
  logic                              shift;

  // A cell takes its neighbor's entry when it lies in the part of the row
  // that moves one place back.
  assign shift = (ctrl_i.lookup_hit & above_match_i)
               | (ctrl_i.ins_evict  & valid_q)
               | (ctrl_i.ins_grow   & prev_i.valid);

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (shift) begin
      valid_d = prev_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp_en) begin
        match_q <= valid_q && (key_q == op_key_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift && !ctrl_i.clear) begin
      key_q   <= prev_i.key;
      value_q <= prev_i.value;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;
  assign match_o       = match_q;
  assign last_o        = valid_q & ~next_valid_i;

endmodule

### rtl/core/lru_cache_table.sv
`timescale 1ns / 1ps
// Top level of the fully associative LRU cache: a row of lct_cell slots kept
// in recency order, with the command sequencer and result register.
// Uses lct_pkg and lct_cell.
//
//  port group    dir  word contents (low bit first)
//  s_axis_*      in   cmd[1:0], key[15:0], value[31:0], zero pad to 56 bits
//  m_axis_*      out  hit, value_out[31:0], evicted, evicted_key[15:0],
//                     count[6:0], zero pad to 64 bits
//  cfg_*         in   capacity[6:0], written whenever cfg_we_i is high
//
// Each word has a compare step, in which every cell compares its key with the
// command key, then an update step: the row shifts and the result register loads.
// Slot 0 is the most recent entry; valid slots always form a prefix.
// Reset clears every valid bit at once, so there is no clearing pass.
// A stalled result holds the row in its update cycle until the result leaves.

module lru_cache_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // cmd, key, value, zero pad
  input  logic [lct_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // hit, value_out, evicted, evicted_key, count, zero pad
  output logic [lct_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [lct_pkg::CAP_W-1:0]    cfg_wdata_i
);

  localparam int N  = lct_pkg::ENTRIES;
  localparam int KW = lct_pkg::KEY_BITS;
  localparam int VW = lct_pkg::VALUE_BITS;
  localparam int CW = lct_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_UPD   = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [lct_pkg::CMD_W-1:0]     cmd_q;
  logic [KW-1:0]                 key_q;
  logic [VW-1:0]                 value_q;
  logic [lct_pkg::CAP_W-1:0]     cap_q;
  logic [CW-1:0]                 count_q, count_d;
  logic                          out_valid_q;
  logic [lct_pkg::OUT_W-1:0]     out_data_q, out_data_d;

  lct_pkg::ctrl_t                ctrl;
  lct_pkg::entry_t               head;
  lct_pkg::entry_t               cell_entry [N];
  logic [N-1:0]                  match_w;
  logic [N-1:0]                  last_w;
  logic [N-1:0]                  above_w;

  logic                          accept;
  logic                          out_free;
  logic                          do_upd;
  logic                          hit;
  logic                          ins_miss;
  logic                          evict;
  logic [31:0]                   eff_cap;
  logic [VW-1:0]                 hit_value;
  logic [KW-1:0]                 last_key;
  logic [VW-1:0]                 value_out;
  logic [KW-1:0]                 evicted_key;

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign do_upd        = (state_q == ST_UPD) && out_free;
  assign s_axis_tready = (state_q == ST_IDLE) || do_upd;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_MATCH;
      ST_MATCH: state_d = ST_UPD;
      ST_UPD: begin
        if (out_free) begin
          state_d = s_axis_tvalid ? ST_MATCH : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Effective capacity: zero acts as one, anything above the row depth as the depth.
  always_comb begin
    eff_cap = 32'(cap_q);
    if (cap_q == '0) begin
      eff_cap = 32'd1;
    end else if (32'(cap_q) > 32'(N)) begin
      eff_cap = 32'(N);
    end
  end

  always_comb begin
    hit_value = '0;
    last_key  = '0;
    for (int i = 0; i < N; i++) begin
      hit_value = hit_value | ({VW{match_w[i]}} & cell_entry[i].value);
      last_key  = last_key  | ({KW{last_w[i]}}  & cell_entry[i].key);
    end
  end

  assign hit      = |match_w;
  assign ins_miss = (cmd_q == lct_pkg::CMD_INSERT) && !hit;
  assign evict    = ins_miss && (32'(count_q) >= eff_cap);

  assign ctrl.cmp_en     = (state_q == ST_MATCH);
  assign ctrl.clear      = do_upd && (cmd_q == lct_pkg::CMD_CLEAR);
  assign ctrl.lookup_hit = do_upd && (cmd_q == lct_pkg::CMD_LOOKUP) && hit;
  assign ctrl.ins_evict  = do_upd && evict;
  assign ctrl.ins_grow   = do_upd && ins_miss && !evict;

  // The entry entering slot 0: the hit entry on a lookup, the new one on insert.
  assign head.valid = 1'b1;
  assign head.key   = key_q;
  assign head.value = (cmd_q == lct_pkg::CMD_LOOKUP) ? hit_value : value_q;

  assign value_out   = ((cmd_q == lct_pkg::CMD_LOOKUP) && hit) ? hit_value : '0;
  assign evicted_key = evict ? last_key : '0;

  always_comb begin
    count_d = count_q;
    if (cmd_q == lct_pkg::CMD_CLEAR) begin
      count_d = '0;
    end else if (ins_miss && !evict) begin
      count_d = count_q + CW'(1);
    end
  end

  always_comb begin
    out_data_d = '0;
    out_data_d[lct_pkg::OUT_BITS-1:0] = {count_d, evicted_key, evict, value_out,
                                         hit && (cmd_q != lct_pkg::CMD_CLEAR)};
  end

  for (genvar i = 0; i < N; i++) begin : g_row
    assign above_w[i] = |match_w[N-1:i];

    lct_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .op_key_i      (key_q),
      .prev_i        ((i == 0) ? head : cell_entry[(i == 0) ? 0 : i - 1]),
      .next_valid_i  ((i == N - 1) ? 1'b0 : cell_entry[(i == N - 1) ? i : i + 1].valid),
      .above_match_i (above_w[i]),
      .entry_o       (cell_entry[i]),
      .match_o       (match_w[i]),
      .last_o        (last_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= lct_pkg::CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (do_upd) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= s_axis_tdata[lct_pkg::CMD_W-1:0];
      key_q   <= s_axis_tdata[lct_pkg::CMD_W +: KW];
      value_q <= s_axis_tdata[lct_pkg::CMD_W + KW +: VW];
    end
    if (do_upd) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/core/lct_checker.sv
`timescale 1ns / 1ps
// Port-level checks for lru_cache_table, attached by the bind at the end.
// Uses lct_pkg for the word layout.

module lct_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [lct_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int VW = lct_pkg::VALUE_BITS;
  localparam int KW = lct_pkg::KEY_BITS;
  localparam int CW = lct_pkg::CNT_W;

  logic          hit;
  logic [VW-1:0] value_out;
  logic          evicted;
  logic [KW-1:0] evicted_key;
  logic [CW-1:0] count;

  assign hit         = m_axis_tdata[0];
  assign value_out   = m_axis_tdata[1 +: VW];
  assign evicted     = m_axis_tdata[1 + VW];
  assign evicted_key = m_axis_tdata[2 + VW +: KW];
  assign count       = m_axis_tdata[2 + VW + KW +: CW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // The key compare has a state of its own, so a word is never taken right after another.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word accepted during key compare");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(count) <= 32'(lct_pkg::ENTRIES))
    else $error("entry count above row depth");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && evicted |-> !hit && count != '0)
    else $error("eviction reported on a hit or an empty table");

  a_payload_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hit |-> value_out == '0 && (evicted || evicted_key == '0))
    else $error("value or evicted key without cause");

endmodule

bind lru_cache_table lct_checker u_lct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
